[design/pstm_pkg.sv]
package pstm_pkg;

   typedef enum logic [1:0] {
      KIND_UP   = 2'd0,
      KIND_DOWN = 2'd1,
      KIND_READ = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_SEND
   } state_type;

   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] FLAG_SYN   = 8'h02;
   localparam logic [7:0] FLAG_RST   = 8'h04;
   localparam logic [7:0] FLAG_ACK   = 8'h10;
   localparam logic [5:0] BIT_SELECT = 6'h3F;
   localparam logic [31:0] RESET_PREFIX = 32'h0a3c0000;
   localparam logic [31:0] RESET_MASK   = 32'hffff0000;

   localparam logic [0:0] CSR_PREFIX = 1'b0;
   localparam logic [0:0] CSR_MASK   = 1'b1;

   localparam logic [3:0] SEL_UP_PACKETS   = 4'd0;
   localparam logic [3:0] SEL_UP_BYTES     = 4'd1;
   localparam logic [3:0] SEL_UP_TCP       = 4'd2;
   localparam logic [3:0] SEL_UP_SYN       = 4'd3;
   localparam logic [3:0] SEL_UP_RST       = 4'd4;
   localparam logic [3:0] SEL_UP_UDP       = 4'd5;
   localparam logic [3:0] SEL_UP_ICMP      = 4'd6;
   localparam logic [3:0] SEL_UP_NEW_FLOWS = 4'd7;
   localparam logic [3:0] SEL_DEST_SPREAD  = 4'd8;
   localparam logic [3:0] SEL_DOWN_PACKETS = 4'd9;
   localparam logic [3:0] SEL_DOWN_BYTES   = 4'd10;
   localparam logic [3:0] SEL_DOWN_TCP     = 4'd11;
   localparam logic [3:0] SEL_DOWN_ACK     = 4'd12;

   typedef struct packed {
      logic clear;
      logic capture;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic needs_write;
   } status_type;

endpackage

[design/pstm_req_if.sv]
interface pstm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] packet_length;
   logic [7:0]  protocol;
   logic [7:0]  flag_bits;
   logic        first_of_flow;
   logic [9:0]  read_entry;
   logic [3:0]  read_counter;

   modport source (output valid, kind, src_addr, dst_addr, packet_length, protocol,
                   flag_bits, first_of_flow, read_entry, read_counter, input ready);
   modport sink (input valid, kind, src_addr, dst_addr, packet_length, protocol,
                 flag_bits, first_of_flow, read_entry, read_counter, output ready);
endinterface

[design/pstm_rsp_if.sv]
interface pstm_rsp_if;
   logic        valid;
   logic        ready;
   logic        counted;
   logic        out_of_range;
   logic        entry_valid;
   logic [63:0] read_value;

   modport source (output valid, counted, out_of_range, entry_valid, read_value,
                   input ready);
   modport sink (input valid, counted, out_of_range, entry_valid, read_value,
                 output ready);
endinterface

[design/pstm_ram.sv]
module pstm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/pstm_ctrl.sv]
module pstm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pstm_pkg::status_type status,
   output pstm_pkg::cmd_type    cmd
);
   pstm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pstm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pstm_pkg::ST_CLEAR: if (status.clear_done) state_in = pstm_pkg::ST_IDLE;
         pstm_pkg::ST_IDLE:  if (req_valid) state_in = pstm_pkg::ST_READ;
         pstm_pkg::ST_READ: begin
            state_in = status.needs_write ? pstm_pkg::ST_WRITE : pstm_pkg::ST_SEND;
         end
         pstm_pkg::ST_WRITE: state_in = pstm_pkg::ST_SEND;
         pstm_pkg::ST_SEND:  if (rsp_ready) state_in = pstm_pkg::ST_IDLE;
         default:            state_in = pstm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.clear   = 1'b0;
      cmd.capture = 1'b0;
      cmd.write   = 1'b0;
      unique case (state_ff)
         pstm_pkg::ST_CLEAR: cmd.clear = 1'b1;
         pstm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         pstm_pkg::ST_READ:  ;
         pstm_pkg::ST_WRITE: cmd.write = 1'b1;
         pstm_pkg::ST_SEND:  rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

[design/pstm_datapath.sv]
module pstm_datapath #(
   parameter int INDEX_BITS      = 10,
   parameter int COUNT_BITS      = 32,
   parameter int BYTE_COUNT_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [31:0]          csr_data,
   input  logic [1:0]           kind,
   input  logic [31:0]          src_addr,
   input  logic [31:0]          dst_addr,
   input  logic [15:0]          packet_length,
   input  logic [7:0]           protocol,
   input  logic [7:0]           flag_bits,
   input  logic                 first_of_flow,
   input  logic [9:0]           read_entry,
   input  logic [3:0]           read_counter,
   input  pstm_pkg::cmd_type    cmd,
   output pstm_pkg::status_type status,
   output logic                 counted,
   output logic                 out_of_range,
   output logic                 entry_valid,
   output logic [63:0]          read_value
);
   localparam int DEPTH = 1 << INDEX_BITS;
   localparam int CB = COUNT_BITS;
   localparam int BB = BYTE_COUNT_BITS;
   // One row holds every counter of an entry plus its valid mark.
   localparam int ROW_BITS = 10 * CB + 2 * BB + 64 + 1;

   typedef struct packed {
      logic          seen;
      logic [CB-1:0] up_packets;
      logic [BB-1:0] up_bytes;
      logic [CB-1:0] up_tcp;
      logic [CB-1:0] up_syn;
      logic [CB-1:0] up_rst;
      logic [CB-1:0] up_udp;
      logic [CB-1:0] up_icmp;
      logic [CB-1:0] up_new_flows;
      logic [63:0]   dest_spread;
      logic [CB-1:0] down_packets;
      logic [BB-1:0] down_bytes;
      logic [CB-1:0] down_tcp;
      logic [CB-1:0] down_ack;
   } row_type;

   logic [31:0] prefix_ff, mask_ff;
   logic [INDEX_BITS:0] clr_ff;
   logic [1:0]  kind_ff;
   logic [31:0] dst_ff;
   logic [15:0] len_ff;
   logic [7:0]  proto_ff, flags_ff;
   logic        fresh_ff, hit_ff, oor_ff, rd_ok_ff;
   logic [3:0]  sel_ff;
   logic [INDEX_BITS-1:0] idx_ff;

   logic [31:0] key;
   logic [31:0] host;
   logic        in_subnet, in_table, rd_ok;
   logic [INDEX_BITS-1:0] idx_in;
   row_type     row_rd, row_wr;
   logic [ROW_BITS-1:0] rd_bits, wr_bits;
   logic        wr_en;
   logic [INDEX_BITS-1:0] wr_addr;
   logic [7:0]  dst_fold;
   logic [5:0]  bit_sel;
   logic        is_tcp;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= pstm_pkg::RESET_PREFIX;
         mask_ff   <= pstm_pkg::RESET_MASK;
         clr_ff    <= '0;
      end else begin
         if (csr_write && csr_index == pstm_pkg::CSR_PREFIX) prefix_ff <= csr_data;
         if (csr_write && csr_index == pstm_pkg::CSR_MASK) mask_ff <= csr_data;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
      end
   end

   assign status.clear_done = clr_ff[INDEX_BITS];

   assign key       = (kind == pstm_pkg::KIND_UP) ? src_addr : dst_addr;
   assign in_subnet = (key & mask_ff) == prefix_ff;
   assign host      = key & ~mask_ff;
   assign in_table  = (host >> INDEX_BITS) == 32'd0;
   assign rd_ok     = ({22'd0, read_entry} >> INDEX_BITS) == 32'd0;

   always_comb begin
      if (kind == pstm_pkg::KIND_READ) begin
         idx_in = INDEX_BITS'({22'd0, read_entry});
      end else begin
         idx_in = host[INDEX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= kind;
         dst_ff   <= dst_addr;
         len_ff   <= packet_length;
         proto_ff <= protocol;
         flags_ff <= flag_bits;
         fresh_ff <= first_of_flow;
         sel_ff   <= read_counter;
         idx_ff   <= idx_in;
         rd_ok_ff <= rd_ok;
         hit_ff   <= (kind == pstm_pkg::KIND_UP || kind == pstm_pkg::KIND_DOWN)
                     && in_subnet && in_table;
         oor_ff   <= (kind == pstm_pkg::KIND_UP || kind == pstm_pkg::KIND_DOWN)
                     && in_subnet && !in_table;
      end
   end

   assign status.needs_write = hit_ff;

   assign row_rd   = row_type'(rd_bits);
   assign dst_fold = dst_ff[7:0] ^ dst_ff[15:8] ^ dst_ff[23:16] ^ dst_ff[31:24];
   assign bit_sel  = dst_fold[5:0] & pstm_pkg::BIT_SELECT;
   assign is_tcp   = proto_ff == pstm_pkg::PROTO_TCP;

   always_comb begin
      row_wr = row_rd;
      row_wr.seen = 1'b1;
      if (kind_ff == pstm_pkg::KIND_UP) begin
         row_wr.up_packets = row_rd.up_packets + 1'b1;
         row_wr.up_bytes   = row_rd.up_bytes + BB'(len_ff);
         if (is_tcp) begin
            row_wr.up_tcp = row_rd.up_tcp + 1'b1;
            if ((flags_ff & pstm_pkg::FLAG_SYN) != 8'd0) row_wr.up_syn = row_rd.up_syn + 1'b1;
            if ((flags_ff & pstm_pkg::FLAG_RST) != 8'd0) row_wr.up_rst = row_rd.up_rst + 1'b1;
         end else if (proto_ff == pstm_pkg::PROTO_UDP) begin
            row_wr.up_udp = row_rd.up_udp + 1'b1;
         end else if (proto_ff == pstm_pkg::PROTO_ICMP) begin
            row_wr.up_icmp = row_rd.up_icmp + 1'b1;
         end
         if (fresh_ff) row_wr.up_new_flows = row_rd.up_new_flows + 1'b1;
         row_wr.dest_spread = row_rd.dest_spread | (64'd1 << bit_sel);
      end else begin
         row_wr.down_packets = row_rd.down_packets + 1'b1;
         row_wr.down_bytes   = row_rd.down_bytes + BB'(len_ff);
         if (is_tcp) begin
            row_wr.down_tcp = row_rd.down_tcp + 1'b1;
            if ((flags_ff & pstm_pkg::FLAG_ACK) != 8'd0) begin
               row_wr.down_ack = row_rd.down_ack + 1'b1;
            end
         end
      end
   end

   // The clearing pass after reset writes zero rows across the table.
   assign wr_en   = cmd.clear || cmd.write;
   assign wr_addr = cmd.clear ? clr_ff[INDEX_BITS-1:0] : idx_ff;
   assign wr_bits = cmd.clear ? '0 : ROW_BITS'(row_wr);

   pstm_ram #(.WIDTH(ROW_BITS), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_bits),
      .rd_addr (idx_ff),
      .rd_data (rd_bits)
   );

   always_comb begin
      counted      = hit_ff;
      out_of_range = oor_ff;
      entry_valid  = 1'b0;
      read_value   = 64'd0;
      if (kind_ff == pstm_pkg::KIND_READ && rd_ok_ff) begin
         entry_valid = row_rd.seen;
         case (sel_ff)
            pstm_pkg::SEL_UP_PACKETS:   read_value = 64'(row_rd.up_packets);
            pstm_pkg::SEL_UP_BYTES:     read_value = 64'(row_rd.up_bytes);
            pstm_pkg::SEL_UP_TCP:       read_value = 64'(row_rd.up_tcp);
            pstm_pkg::SEL_UP_SYN:       read_value = 64'(row_rd.up_syn);
            pstm_pkg::SEL_UP_RST:       read_value = 64'(row_rd.up_rst);
            pstm_pkg::SEL_UP_UDP:       read_value = 64'(row_rd.up_udp);
            pstm_pkg::SEL_UP_ICMP:      read_value = 64'(row_rd.up_icmp);
            pstm_pkg::SEL_UP_NEW_FLOWS: read_value = 64'(row_rd.up_new_flows);
            pstm_pkg::SEL_DEST_SPREAD:  read_value = row_rd.dest_spread;
            pstm_pkg::SEL_DOWN_PACKETS: read_value = 64'(row_rd.down_packets);
            pstm_pkg::SEL_DOWN_BYTES:   read_value = 64'(row_rd.down_bytes);
            pstm_pkg::SEL_DOWN_TCP:     read_value = 64'(row_rd.down_tcp);
            pstm_pkg::SEL_DOWN_ACK:     read_value = 64'(row_rd.down_ack);
            default:                    read_value = 64'd0;
         endcase
      end
   end
endmodule

[design/per_subscriber_traffic_meter_unit.sv]
// An accepted beat is registered, its table row is read in READ, written back in WRITE
// for packets that update the table (reads and uncounted packets skip WRITE), then sent in SEND.
// A new beat is taken only after the previous response has been accepted; every beat reads
// one table row and a counted packet writes it back, through the single RAM port pair, one at a time.
// Reset clears the subnet registers to 10.60.0.0/16 and then runs a clearing pass over all
// 2^INDEX_BITS table rows (1024 by default) before the first request beat is accepted.
module per_subscriber_traffic_meter_unit #(
   parameter int INDEX_BITS      = 10,
   parameter int COUNT_BITS      = 32,
   parameter int BYTE_COUNT_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   pstm_req_if.sink    req,
   pstm_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   pstm_pkg::cmd_type    cmd;
   pstm_pkg::status_type status;

   pstm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pstm_datapath #(
      .INDEX_BITS      (INDEX_BITS),
      .COUNT_BITS      (COUNT_BITS),
      .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .kind          (req.kind),
      .src_addr      (req.src_addr),
      .dst_addr      (req.dst_addr),
      .packet_length (req.packet_length),
      .protocol      (req.protocol),
      .flag_bits     (req.flag_bits),
      .first_of_flow (req.first_of_flow),
      .read_entry    (req.read_entry),
      .read_counter  (req.read_counter),
      .cmd           (cmd),
      .status        (status),
      .counted       (rsp.counted),
      .out_of_range  (rsp.out_of_range),
      .entry_valid   (rsp.entry_valid),
      .read_value    (rsp.read_value)
   );
endmodule
